FILE: rtl/csvfs_pkg.sv
// csvfs_pkg: types, codes and constants shared by the field scanner modules.
// No dependencies.
package csvfs_pkg;

    localparam int MAX_COLUMNS_DEF = 256;
    localparam int ROW_LIMIT_DEF   = 1048576;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam int COL_W    = 8;
    localparam int ROW_W    = 21;
    localparam int OUT_OFS_W = 32;
    localparam int CFG_W    = 9;

    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [7:0] BYTE_QUOTE   = 8'h22;

    typedef enum logic [1:0] {
        CFG_DELIMITER  = 2'd0,
        CFG_FIRST_COL  = 2'd1,
        CFG_LAST_COL   = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EOI      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        EVT_FIELD = 2'd0,
        EVT_ROW   = 2'd1,
        EVT_EOI   = 2'd2
    } t_evt_kind;

    typedef struct packed {
        logic [7:0]       delimiter;
        logic [COL_W-1:0] first_col;
        logic [CFG_W-1:0] last_col;
    } t_cfg;

endpackage

FILE: rtl/csvfs_in_if.sv
// csvfs_in_if: input channel of the field scanner, one text word per handshake.
// Depends on nothing.
interface csvfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
    modport monitor (input valid, input ready, input data_byte, input end_of_input);
endinterface

FILE: rtl/csvfs_out_if.sv
// csvfs_out_if: result channel of the field scanner, one field record per word.
// Depends on nothing.
interface csvfs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  column_index;
    logic [31:0] field_start;
    logic [31:0] field_length;
    logic [20:0] row_index;
    logic        end_of_row;
    logic        selected;
    logic [1:0]  status;

    modport source (output valid, output column_index, output field_start,
                    output field_length, output row_index, output end_of_row,
                    output selected, output status, input ready);
    modport sink (input valid, input column_index, input field_start,
                  input field_length, input row_index, input end_of_row,
                  input selected, input status, output ready);
    modport monitor (input valid, input ready, input column_index, input field_start,
                     input field_length, input row_index, input end_of_row,
                     input selected, input status);
endinterface

FILE: rtl/csvfs_front.sv
// csvfs_front: accepts text words, tracks quoting and byte offset, and
// emits field-end and end-of-input events. Depends on csvfs_pkg and csvfs_in_if.
module csvfs_front #(
    parameter int OFFSET_BITS = csvfs_pkg::OFFSET_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  csvfs_pkg::t_cfg         i_cfg,
    csvfs_in_if.sink                i_in,
    input  logic                    i_full,
    output logic                    o_push,
    output csvfs_pkg::t_evt_kind    o_push_kind,
    output logic [OFFSET_BITS-1:0]  o_push_offset
);

    logic                   r_quote;
    logic                   n_quote;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [OFFSET_BITS-1:0] n_offset;
    logic                   w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    always_comb begin
        n_quote       = r_quote;
        n_offset      = r_offset;
        o_push        = 1'b0;
        o_push_kind   = csvfs_pkg::EVT_FIELD;
        o_push_offset = r_offset;
        if (w_accept) begin
            if (i_in.end_of_input) begin
                o_push      = 1'b1;
                o_push_kind = csvfs_pkg::EVT_EOI;
                n_quote     = 1'b0;
            end else begin
                n_offset = r_offset + 1'b1;
                if (i_in.data_byte == csvfs_pkg::BYTE_ZERO) begin
                    o_push  = 1'b1;
                    n_quote = 1'b0;
                end else if (i_in.data_byte == csvfs_pkg::BYTE_NEWLINE) begin
                    o_push      = 1'b1;
                    o_push_kind = csvfs_pkg::EVT_ROW;
                    n_quote     = 1'b0;
                end else if (i_in.data_byte == csvfs_pkg::BYTE_QUOTE) begin
                    n_quote = !r_quote;
                end else if (i_in.data_byte == i_cfg.delimiter && !r_quote) begin
                    o_push  = 1'b1;
                    n_quote = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote  <= 1'b0;
            r_offset <= '0;
        end else begin
            r_quote  <= n_quote;
            r_offset <= n_offset;
        end
    end

endmodule

FILE: rtl/csvfs_queue.sv
// csvfs_queue: small FIFO of field-end and end-of-input events between front and back.
// Depends on csvfs_pkg.
module csvfs_queue #(
    parameter int DATA_W = 2 + csvfs_pkg::OFFSET_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = csvfs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/csvfs_back.sv
// csvfs_back: turns field-end events into result words; keeps column, row
// and field-start state and the output register. Depends on csvfs_pkg, csvfs_out_if.
module csvfs_back #(
    parameter int MAX_COLUMNS = csvfs_pkg::MAX_COLUMNS_DEF,
    parameter int ROW_LIMIT   = csvfs_pkg::ROW_LIMIT_DEF,
    parameter int OFFSET_BITS = csvfs_pkg::OFFSET_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  csvfs_pkg::t_cfg        i_cfg,
    input  logic                   i_empty,
    input  csvfs_pkg::t_evt_kind   i_kind,
    input  logic [OFFSET_BITS-1:0] i_offset,
    output logic                   o_pop,
    csvfs_out_if.source            o_out
);

    localparam int COL_W   = csvfs_pkg::COL_W;
    localparam int ROW_W   = csvfs_pkg::ROW_W;
    localparam int OW      = csvfs_pkg::OUT_OFS_W;
    localparam int COL_MAX = (1 << COL_W) - 1;
    localparam int ROW_MAX = (1 << ROW_W) - 1;
    localparam int COL_CAP = (MAX_COLUMNS - 1 > COL_MAX) ? COL_MAX : MAX_COLUMNS - 1;
    localparam int ROW_CAP = (ROW_LIMIT > ROW_MAX) ? ROW_MAX : ROW_LIMIT;

    logic [OFFSET_BITS-1:0] r_field_begin;
    logic [OFFSET_BITS-1:0] n_field_begin;
    logic [COL_W-1:0]       r_col;
    logic [COL_W-1:0]       n_col;
    logic [COL_W:0]         r_col_count;
    logic [COL_W:0]         n_col_count;
    logic [ROW_W-1:0]       r_row;
    logic [ROW_W-1:0]       n_row;

    logic                   r_out_valid;
    logic [COL_W-1:0]       r_out_col;
    logic [OW-1:0]          r_out_start;
    logic [OW-1:0]          r_out_len;
    logic [ROW_W-1:0]       r_out_row;
    logic                   r_out_eor;
    logic                   r_out_sel;
    csvfs_pkg::t_status     r_out_status;

    logic [COL_W-1:0]       n_out_col;
    logic [OW-1:0]          n_out_start;
    logic [OW-1:0]          n_out_len;
    logic                   n_out_eor;
    logic                   n_out_sel;
    csvfs_pkg::t_status     n_out_status;

    logic [OFFSET_BITS-1:0] w_len;
    logic [63:0]            w_begin_wide;
    logic [63:0]            w_len_wide;
    logic [COL_W:0]         w_col_p1;
    logic                   w_in_window;

    assign o_pop        = !i_empty && (!r_out_valid || o_out.ready);
    assign w_len        = i_offset - r_field_begin;
    assign w_begin_wide = 64'(r_field_begin);
    assign w_len_wide   = 64'(w_len);
    assign w_col_p1     = {1'b0, r_col} + 1'b1;
    assign w_in_window  = (r_col >= i_cfg.first_col) &&
                          (i_cfg.last_col[COL_W] || r_col <= i_cfg.last_col[COL_W-1:0]);

    always_comb begin
        n_field_begin = r_field_begin;
        n_col         = r_col;
        n_col_count   = r_col_count;
        n_row         = r_row;
        n_out_col     = r_col;
        n_out_start   = w_begin_wide[OW-1:0];
        n_out_len     = w_len_wide[OW-1:0];
        n_out_eor     = 1'b0;
        n_out_sel     = w_in_window;
        n_out_status  = csvfs_pkg::ST_OK;
        case (i_kind)
            csvfs_pkg::EVT_EOI: begin
                n_out_col     = '0;
                n_out_start   = '0;
                n_out_len     = '0;
                n_out_sel     = 1'b0;
                n_out_status  = csvfs_pkg::ST_EOI;
                n_field_begin = i_offset;
            end
            csvfs_pkg::EVT_ROW: begin
                n_out_eor     = 1'b1;
                n_field_begin = i_offset + 1'b1;
                if (r_col_count == '0) begin
                    n_col_count = w_col_p1;
                end else if (w_col_p1 != r_col_count) begin
                    n_out_status = csvfs_pkg::ST_MISMATCH;
                end
                if (r_row < ROW_W'(ROW_CAP)) begin
                    n_row = r_row + 1'b1;
                end
                n_col = '0;
            end
            default: begin
                n_field_begin = i_offset + 1'b1;
                if (r_col < COL_W'(COL_CAP)) begin
                    n_col = r_col + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_begin <= '0;
            r_col         <= '0;
            r_col_count   <= '0;
            r_row         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_field_begin <= n_field_begin;
                r_col         <= n_col;
                r_col_count   <= n_col_count;
                r_row         <= n_row;
                r_out_valid   <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_col    <= n_out_col;
            r_out_start  <= n_out_start;
            r_out_len    <= n_out_len;
            r_out_row    <= r_row;
            r_out_eor    <= n_out_eor;
            r_out_sel    <= n_out_sel;
            r_out_status <= n_out_status;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.column_index = r_out_col;
    assign o_out.field_start  = r_out_start;
    assign o_out.field_length = r_out_len;
    assign o_out.row_index    = r_out_row;
    assign o_out.end_of_row   = r_out_eor;
    assign o_out.selected     = r_out_sel;
    assign o_out.status       = r_out_status;

endmodule

FILE: rtl/csv_field_scanner_core.sv
// csv_field_scanner_core: top level of the delimited-text field scanner.
// Depends on csvfs_pkg, csvfs_in_if, csvfs_out_if, csvfs_front, csvfs_queue, csvfs_back.
//
// Takes one text byte (or an end-of-input mark) per clock, and can accept
// a byte every cycle while the event queue is not full; gives one field
// record per field end, plus one record per end-of-input carrying the row
// count. The front classifier writes each event into the event queue;
// the back unit then updates column and row state and loads the output
// register. The two-entry event queue lets input keep flowing for two
// field ends while the result side is stalled. Configuration writes take
// effect on the next cycle and belong only to idle periods.
module csv_field_scanner_core #(
    parameter int MAX_COLUMNS = csvfs_pkg::MAX_COLUMNS_DEF,
    parameter int ROW_LIMIT   = csvfs_pkg::ROW_LIMIT_DEF,
    parameter int OFFSET_BITS = csvfs_pkg::OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [csvfs_pkg::CFG_W-1:0]   i_cfg_data,
    csvfs_in_if.sink                      i_in,
    csvfs_out_if.source                   o_out
);

    localparam int KIND_W = $bits(csvfs_pkg::t_evt_kind);
    localparam int Q_W    = KIND_W + OFFSET_BITS;

    csvfs_pkg::t_cfg        r_cfg;
    logic                   w_push;
    csvfs_pkg::t_evt_kind   w_push_kind;
    logic [OFFSET_BITS-1:0] w_push_offset;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_pop;
    logic [Q_W-1:0]         w_head;
    csvfs_pkg::t_evt_kind   w_head_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter <= 8'd44;
            r_cfg.first_col <= '0;
            r_cfg.last_col  <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                csvfs_pkg::CFG_DELIMITER: r_cfg.delimiter <= i_cfg_data[7:0];
                csvfs_pkg::CFG_FIRST_COL: r_cfg.first_col <= i_cfg_data[csvfs_pkg::COL_W-1:0];
                csvfs_pkg::CFG_LAST_COL:  r_cfg.last_col  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    csvfs_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in          (i_in),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_push_kind   (w_push_kind),
        .o_push_offset (w_push_offset)
    );

    csvfs_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_push_kind, w_push_offset}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head)
    );

    assign w_head_kind = csvfs_pkg::t_evt_kind'(w_head[Q_W-1 -: KIND_W]);

    csvfs_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ROW_LIMIT   (ROW_LIMIT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (w_empty),
        .i_kind   (w_head_kind),
        .i_offset (w_head[OFFSET_BITS-1:0]),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule

FILE: rtl/csvfs_checker.sv
// csvfs_checker: port-level checks on the scanner's result channel, bound to
// the top level. Depends on csvfs_pkg and csv_field_scanner_core.
module csvfs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [7:0]  i_column_index,
    input  logic [31:0] i_field_start,
    input  logic [31:0] i_field_length,
    input  logic        i_end_of_row,
    input  logic        i_selected,
    input  logic [1:0]  i_status
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_field_start)
            && $stable(i_status))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_eoi_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == csvfs_pkg::ST_EOI |->
            i_column_index == '0 && i_field_length == '0 &&
            !i_end_of_row && !i_selected)
        else $error("end-of-input word carries field data");

    a_mismatch_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == csvfs_pkg::ST_MISMATCH |-> i_end_of_row)
        else $error("field count mismatch off a row end");

endmodule

bind csv_field_scanner_core csvfs_checker u_csvfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_column_index (o_out.column_index),
    .i_field_start  (o_out.field_start),
    .i_field_length (o_out.field_length),
    .i_end_of_row   (o_out.end_of_row),
    .i_selected     (o_out.selected),
    .i_status       (o_out.status)
);

FILE: verif/csv_field_scanner_core_test.sv
// csv_field_scanner_core_test: self-checking bench for the field scanner core.
// Depends on csvfs_pkg, csvfs_in_if, csvfs_out_if and csv_field_scanner_core.
// Streams directed and random delimited text and checks every field record.
module csv_field_scanner_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  COL_CAP = 8'd255;
    localparam logic [20:0] ROW_CAP = 21'd1048576;

    typedef struct packed {
        logic [7:0]         column_index;
        logic [31:0]        field_start;
        logic [31:0]        field_length;
        logic [20:0]        row_index;
        logic               end_of_row;
        logic               selected;
        csvfs_pkg::t_status status;
    } t_field_rec;

    class field_tracker;
        logic [7:0]  delim = 8'd44;
        logic [7:0]  first_col = 8'd0;
        logic [8:0]  last_col = 9'h1FF;
        bit          quote_open = 1'b0;
        logic [31:0] byte_offset = '0;
        logic [31:0] field_begin = '0;
        logic [7:0]  cur_col = '0;
        logic [8:0]  col_count = '0;
        logic [20:0] row_count = '0;
        t_field_rec  expected_fields [$];
        int          failures = 0;

        function void set_reg(csvfs_pkg::t_cfg_index idx, logic [8:0] val);
            case (idx)
                csvfs_pkg::CFG_DELIMITER: delim = val[7:0];
                csvfs_pkg::CFG_FIRST_COL: first_col = val[7:0];
                csvfs_pkg::CFG_LAST_COL:  last_col = val;
                default: ;
            endcase
        endfunction

        function logic in_window(logic [7:0] col);
            if (col < first_col) return 1'b0;
            if (last_col[8]) return 1'b1;
            return col <= last_col[7:0];
        endfunction

        function void end_field(logic [31:0] here, bit row_end);
            t_field_rec r;
            r.column_index = cur_col;
            r.field_start = field_begin;
            r.field_length = here - field_begin;
            r.row_index = row_count;
            r.end_of_row = row_end;
            r.selected = in_window(cur_col);
            r.status = csvfs_pkg::ST_OK;
            if (row_end) begin
                if (col_count == 9'd0) begin
                    col_count = {1'b0, cur_col} + 9'd1;
                end else if ({1'b0, cur_col} + 9'd1 != col_count) begin
                    r.status = csvfs_pkg::ST_MISMATCH;
                end
                if (row_count < ROW_CAP) row_count++;
                cur_col = 8'd0;
            end else if (cur_col < COL_CAP) begin
                cur_col++;
            end
            field_begin = here + 32'd1;
            quote_open = 1'b0;
            expected_fields.push_back(r);
        endfunction

        function void take_word(logic [7:0] b, logic eoi);
            t_field_rec r;
            logic [31:0] here;
            if (eoi) begin
                r = '0;
                r.row_index = row_count;
                r.status = csvfs_pkg::ST_EOI;
                expected_fields.push_back(r);
                field_begin = byte_offset;
                quote_open = 1'b0;
                return;
            end
            here = byte_offset;
            byte_offset = here + 32'd1;
            if (b == csvfs_pkg::BYTE_ZERO) end_field(here, 1'b0);
            else if (b == csvfs_pkg::BYTE_NEWLINE) end_field(here, 1'b1);
            else if (b == csvfs_pkg::BYTE_QUOTE) quote_open = !quote_open;
            else if (b == delim && !quote_open) end_field(here, 1'b0);
        endfunction

        function void check_value(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        function void check_field(t_field_rec got);
            t_field_rec want;
            if (expected_fields.size() == 0) begin
                $error("unexpected field record: column %0d row %0d status %0d",
                       got.column_index, got.row_index, got.status);
                failures++;
                return;
            end
            want = expected_fields.pop_front();
            check_value("column_index", want.column_index, got.column_index);
            check_value("field_start", want.field_start, got.field_start);
            check_value("field_length", want.field_length, got.field_length);
            check_value("row_index", want.row_index, got.row_index);
            check_value("end_of_row", want.end_of_row, got.end_of_row);
            check_value("selected", want.selected, got.selected);
            check_value("status", want.status, got.status);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    csvfs_in_if  in_ch ();
    csvfs_out_if out_ch ();

    csv_field_scanner_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    field_tracker tracker = new();
    bit           steady;
    int           sent;

    logic [7:0] ph_delim [7] = '{8'd9, 8'd255, 8'd34, 8'd10, 8'd0, 8'd59, 8'd44};
    logic [7:0] ph_first [7] = '{8'd1, 8'd0, 8'd0, 8'd2, 8'd255, 8'd1, 8'd0};
    logic [8:0] ph_last  [7] = '{9'd2, 9'd0, 9'h100, 9'd255, 9'h1FF, 9'd1, 9'h1FF};

    logic [8:0] opening [21] = '{
        {1'b0, "a"}, {1'b0, ","}, {1'b0, csvfs_pkg::BYTE_QUOTE}, {1'b0, ","},
        {1'b0, csvfs_pkg::BYTE_QUOTE}, {1'b0, csvfs_pkg::BYTE_NEWLINE},
        {1'b0, csvfs_pkg::BYTE_QUOTE}, {1'b0, "b"}, {1'b0, csvfs_pkg::BYTE_NEWLINE},
        {1'b0, csvfs_pkg::BYTE_ZERO}, {1'b0, 8'hFF}, {1'b0, ","},
        {1'b0, csvfs_pkg::BYTE_NEWLINE},
        {1'b0, "x"}, {1'b0, "y"}, {1'b1, 8'h5A}, {1'b1, 8'hFF}, {1'b0, ","},
        {1'b0, csvfs_pkg::BYTE_NEWLINE}, {1'b0, 8'h80}, {1'b0, csvfs_pkg::BYTE_NEWLINE}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(32, 126));
        while (b == csvfs_pkg::BYTE_QUOTE || b == tracker.delim);
        return b;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_input <= eoi;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.take_word(b, eoi);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.expected_fields.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input csvfs_pkg::t_cfg_index idx, input logic [8:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        tracker.set_reg(idx, val);
    endtask

    task automatic send_row(input int ncols);
        bit quoted;
        int len;
        for (int c = 0; c < ncols; c++) begin
            quoted = ($urandom_range(0, 3) == 0);
            len = $urandom_range(0, 5);
            if (quoted) send_word(csvfs_pkg::BYTE_QUOTE, 1'b0);
            for (int k = 0; k < len; k++)
                send_word((quoted && $urandom_range(0, 4) == 0) ? tracker.delim : text_byte(),
                          1'b0);
            if (quoted) send_word(csvfs_pkg::BYTE_QUOTE, 1'b0);
            send_word((c == ncols - 1) ? csvfs_pkg::BYTE_NEWLINE : tracker.delim, 1'b0);
        end
    endtask

    task automatic send_noise();
        int n;
        logic [7:0] b;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0: b = csvfs_pkg::BYTE_ZERO;
                1: b = csvfs_pkg::BYTE_NEWLINE;
                2: b = csvfs_pkg::BYTE_QUOTE;
                3: b = tracker.delim;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(b, 1'b0);
        end
    endtask

    // result side: sample at the edge, then pick the next ready
    initial begin : result_sink
        int stall_left;
        t_field_rec got;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got.column_index = out_ch.column_index;
                got.field_start = out_ch.field_start;
                got.field_length = out_ch.field_length;
                got.row_index = out_ch.row_index;
                got.end_of_row = out_ch.end_of_row;
                got.selected = out_ch.selected;
                got.status = csvfs_pkg::t_status'(out_ch.status);
                tracker.check_field(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        int goal;
        int r;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= csvfs_pkg::CFG_DELIMITER;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.end_of_input <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[k]) send_word(opening[k][7:0], opening[k][8]);

        for (int p = 0; p < 7; p++) begin
            drain();
            write_reg(csvfs_pkg::CFG_DELIMITER, {1'b0, ph_delim[p]});
            write_reg(csvfs_pkg::CFG_FIRST_COL, {1'b0, ph_first[p]});
            write_reg(csvfs_pkg::CFG_LAST_COL, ph_last[p]);
            steady = (p % 3 == 2);
            // one very wide row drives the column counter into saturation
            if (p == 4) begin
                for (int k = 0; k < 260; k++) send_word(tracker.delim, 1'b0);
                send_word(csvfs_pkg::BYTE_NEWLINE, 1'b0);
            end
            goal = sent + 14;
            while (sent < goal) begin
                r = $urandom_range(0, 99);
                if (r < 70) send_row(($urandom_range(0, 9) < 6) ? 2 : $urandom_range(1, 8));
                else if (r < 85) send_noise();
                else if (r < 92) send_word(8'($urandom_range(0, 255)), 1'b1);
                else begin
                    send_word(csvfs_pkg::BYTE_QUOTE, 1'b0);
                    send_word(text_byte(), 1'b0);
                    send_word(($urandom_range(0, 1) == 0) ? csvfs_pkg::BYTE_NEWLINE
                                                          : csvfs_pkg::BYTE_ZERO, 1'b0);
                end
            end
        end

        drain();
        if (tracker.failures == 0 && tracker.expected_fields.size() == 0)
            $display("csv_field_scanner_core verification clean");
        else
            $display("csv_field_scanner_core verification failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("csv_field_scanner_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/csvfs_pkg.sv
rtl/csvfs_in_if.sv
rtl/csvfs_out_if.sv
rtl/csvfs_front.sv
rtl/csvfs_queue.sv
rtl/csvfs_back.sv
rtl/csv_field_scanner_core.sv
rtl/csvfs_checker.sv
verif/csv_field_scanner_core_test.sv
